>>> rtl/fws_pkg.sv
package fws_pkg;

  // Default sizing of the stack
  localparam int unsigned DEPTH_DEF      = 32;
  localparam int unsigned FLAG_WIDTH_DEF = 8;

  // Field widths on the stream ports
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned TOP_W    = 8;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 8;

  // Stack operations carried in each input beat
  typedef enum logic [ACTION_W-1:0] {
    ACT_READ  = 3'd0,
    ACT_LOAD  = 3'd1,
    ACT_PUSH  = 3'd2,
    ACT_POP   = 3'd3,
    ACT_SWAP  = 3'd4,
    ACT_SET   = 3'd5,
    ACT_CLR   = 3'd6,
    ACT_RESET = 3'd7
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Result of one operation, as reported on the output stream
  typedef struct packed {
    status_t              status;
    logic [LEVEL_W-1:0]   level;
    logic [TOP_W-1:0]     top_flags;
  } res_t;

endpackage

>>> rtl/fws_ram.sv
module fws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fws_core.sv
module fws_core #(
  parameter int unsigned DEPTH      = fws_pkg::DEPTH_DEF,
  parameter int unsigned FLAG_WIDTH = fws_pkg::FLAG_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  fws_pkg::action_t             act,
  input  logic [fws_pkg::VALUE_W-1:0]  flag_value,
  input  logic [fws_pkg::CFG_W-1:0]    default_flags,
  output fws_pkg::res_t                res
);

  localparam int unsigned LW = $clog2(DEPTH);

  // Top entry lives in a register; entries below it live in the RAM
  logic [LW-1:0]         t;
  logic [LW-1:0]         t_next;
  logic [FLAG_WIDTH-1:0] top;
  logic [FLAG_WIDTH-1:0] top_next;
  logic [DEPTH-1:0]      valid;
  logic [DEPTH-1:0]      valid_next;
  logic [DEPTH-1:0]      valid_set;

  // Neighbor entry, prefetched from the RAM's registered read port
  logic                  byp;
  logic [FLAG_WIDTH-1:0] byp_data;
  logic                  vld;
  logic [FLAG_WIDTH-1:0] ram_q;
  logic [FLAG_WIDTH-1:0] nbr;

  logic                  we;
  logic [LW-1:0]         waddr;
  logic [FLAG_WIDTH-1:0] wdata;
  logic                  clr;
  logic [LW-1:0]         ra;
  logic [LW-1:0]         other;
  logic                  full;
  fws_pkg::status_t      status;

  logic [FLAG_WIDTH+fws_pkg::VALUE_W-1:0] val_wide;
  logic [FLAG_WIDTH+fws_pkg::CFG_W-1:0]   dflt_wide;
  logic [FLAG_WIDTH+fws_pkg::TOP_W-1:0]   top_wide;
  logic [LW+fws_pkg::LEVEL_W-1:0]         lvl_wide;
  logic [FLAG_WIDTH-1:0]                  val;
  logic [FLAG_WIDTH-1:0]                  dflt;

  // Fit the 8-bit fields to the flag width
  assign val_wide  = {{FLAG_WIDTH{1'b0}}, flag_value};
  assign dflt_wide = {{FLAG_WIDTH{1'b0}}, default_flags};
  assign val       = val_wide[FLAG_WIDTH-1:0];
  assign dflt      = dflt_wide[FLAG_WIDTH-1:0];

  // Entry below the top, or entry 1 at the bottom; unwritten entries read as zero
  assign nbr   = byp ? byp_data : (vld ? ram_q : '0);
  assign other = (t == '0) ? LW'(1) : t - LW'(1);
  assign full  = (t == LW'(DEPTH - 1));

  // Apply the operation
  always_comb begin
    t_next   = t;
    top_next = top;
    we       = 1'b0;
    waddr    = t;
    wdata    = top;
    clr      = 1'b0;
    status   = fws_pkg::ST_OK;
    if (go) begin
      unique case (act)
        fws_pkg::ACT_READ: begin
        end
        fws_pkg::ACT_LOAD: begin
          top_next = val;
        end
        fws_pkg::ACT_PUSH: begin
          if (full) begin
            status = fws_pkg::ST_OVERFLOW;
          end else begin
            we     = 1'b1;
            t_next = t + LW'(1);
          end
        end
        fws_pkg::ACT_POP: begin
          if (t == '0) begin
            status = fws_pkg::ST_UNDERFLOW;
          end else begin
            we       = 1'b1;
            t_next   = t - LW'(1);
            top_next = nbr;
          end
        end
        fws_pkg::ACT_SWAP: begin
          we       = 1'b1;
          waddr    = other;
          top_next = nbr;
        end
        fws_pkg::ACT_SET: begin
          top_next = top | val;
        end
        fws_pkg::ACT_CLR: begin
          top_next = top & ~val;
        end
        fws_pkg::ACT_RESET: begin
          clr      = 1'b1;
          t_next   = '0;
          top_next = dflt;
        end
      endcase
    end
  end

  // Prefetch the neighbor of the next top
  assign ra = (t_next == '0) ? LW'(1) : t_next - LW'(1);

  always_comb begin
    valid_set = '0;
    valid_set[waddr] = we;
    valid_next = clr ? '0 : (valid | valid_set);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t     <= '0;
      top   <= '0;
      valid <= '0;
      byp   <= 1'b0;
      vld   <= 1'b0;
    end else begin
      t     <= t_next;
      top   <= top_next;
      valid <= valid_next;
      byp   <= we && (waddr == ra);
      vld   <= valid_next[ra];
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wdata;
  end

  fws_ram #(
    .WIDTH (FLAG_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra),
    .rdata (ram_q)
  );

  // Report the state after the operation
  assign top_wide      = {{fws_pkg::TOP_W{1'b0}}, top_next};
  assign lvl_wide      = {{fws_pkg::LEVEL_W{1'b0}}, t_next};
  assign res.top_flags = top_wide[fws_pkg::TOP_W-1:0];
  assign res.level     = lvl_wide[fws_pkg::LEVEL_W-1:0];
  assign res.status    = status;

  a_pop_bottom_holds: assert property (@(posedge clk) disable iff (rst)
    (go && act == fws_pkg::ACT_POP && t == '0) |=> (t == '0))
    else $error("pop at bottom moved the top");

  a_push_full_holds: assert property (@(posedge clk) disable iff (rst)
    (go && act == fws_pkg::ACT_PUSH && full) |=> (t == LW'(DEPTH - 1)))
    else $error("push on full stack moved the top");

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (rst)
    !(we && clr))
    else $error("RAM write during stack clear");

  a_prefetch_not_top: assert property (@(posedge clk) disable iff (rst)
    ra != t_next)
    else $error("prefetch address hits the top entry");

  a_overflow_only_push: assert property (@(posedge clk) disable iff (rst)
    (res.status == fws_pkg::ST_OVERFLOW) |-> (go && act == fws_pkg::ACT_PUSH))
    else $error("overflow reported outside a push");

endmodule

>>> rtl/flag_word_stack.sv
// Output: the result of an accepted beat is registered into m_tdata when the beat is taken.
// Throughput: one beat per cycle unless m_tready stalls; the top entry is a register and
// the entry below it is prefetched from the stack RAM's registered read port every cycle.
// Reset: one bottom entry of zero, default_flags zero, output empty; entries above
// the bottom read as zero through per-entry valid bits, so no clearing pass is run.
module flag_word_stack #(
  parameter int unsigned DEPTH      = fws_pkg::DEPTH_DEF,
  parameter int unsigned FLAG_WIDTH = fws_pkg::FLAG_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,     // action[2:0], flag_value[10:3], zero pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,     // top_flags[7:0], level[12:8], status[14:13]
  input  logic                      cfg_wr_en,
  input  logic [fws_pkg::CFG_W-1:0] cfg_wr_data  // default_flags
);

  logic                      go;
  logic [fws_pkg::CFG_W-1:0] default_flags;
  fws_pkg::res_t             res;

  // Take a beat whenever the output register is free or draining, never in reset
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign go       = s_tvalid && s_tready;

  // Hold the configured bottom word
  always_ff @(posedge clk) begin
    if (rst) begin
      default_flags <= '0;
    end else if (cfg_wr_en) begin
      default_flags <= cfg_wr_data;
    end
  end

  fws_core #(
    .DEPTH      (DEPTH),
    .FLAG_WIDTH (FLAG_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .act           (fws_pkg::action_t'(s_tdata[2:0])),
    .flag_value    (s_tdata[10:3]),
    .default_flags (default_flags),
    .res           (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {1'b0, res.status, res.level, res.top_flags};
    end
  end

endmodule
